// ===== hdl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Used by tcw_ctrl, tcw_dp and text_console_writer; depends on nothing.
package tcw_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic step;      // advance the screen sweep by one cell
    logic load_out;  // load the result register
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic put_scroll;  // the offered put would scroll the screen
    logic sweep_last;  // sweep sits on the last cell
  } tcw_stat_t;

endpackage

// ===== hdl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/tcw_ctrl.sv =====
// Controller of the text console writer: handshakes, sequencing of
// puts, reads and screen sweeps. Depends on tcw_pkg.
module tcw_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tcw_pkg::CMD_W-1:0]      cmd_in,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  tcw_pkg::tcw_stat_t             stat,
  output tcw_pkg::tcw_cmd_t              ctl
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT      = 3'd0;
  localparam logic [2:0] S_INIT_END  = 3'd1;
  localparam logic [2:0] S_IDLE      = 3'd2;
  localparam logic [2:0] S_RD        = 3'd3;
  localparam logic [2:0] S_SWEEP     = 3'd4;
  localparam logic [2:0] S_SWEEP_END = 3'd5;

  logic [2:0] state, state_next;
  logic       out_valid, out_valid_next;
  logic       accept;

  assign s_tready = (state == S_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.accept = accept;
    case (state)
      S_INIT: begin
        ctl.step = 1'b1;
        if (stat.sweep_last) state_next = S_INIT_END;
      end
      S_INIT_END: state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_PUT: begin
              if (stat.put_scroll) state_next = S_SWEEP;
              else ctl.load_out = 1'b1;
            end
            CMD_CLEAR: state_next = S_SWEEP;
            CMD_READ:  state_next = S_RD;
            default:   ctl.load_out = 1'b1;
          endcase
        end
      end
      S_RD: begin
        ctl.load_out = 1'b1;
        state_next   = S_IDLE;
      end
      S_SWEEP: begin
        ctl.step = 1'b1;
        if (stat.sweep_last) state_next = S_SWEEP_END;
      end
      S_SWEEP_END: begin
        ctl.load_out = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = ctl.load_out || (out_valid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || m_tready))
    else $error("result register overwritten while held");

  a_init_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT || state == S_INIT_END) |-> !out_valid && !s_tready)
    else $error("activity during the reset clearing pass");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> !accept && !ctl.load_out)
    else $error("item taken or result loaded during a sweep");
`endif

endmodule

// ===== hdl/tcw_dp.sv =====
// Datapath of the text console writer: cursor, screen store, sweep
// counter with copy stage, configuration and result registers.
// Depends on tcw_pkg and tcw_ram.
module tcw_dp #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tcw_pkg::tcw_cmd_t             ctl,
  output tcw_pkg::tcw_stat_t            stat,
  input  logic                          cfg_valid,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data,
  input  logic [tcw_pkg::CMD_W-1:0]     cmd_in,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]    attr,
  input  logic                          use_cursor,
  input  logic [tcw_pkg::COL_W-1:0]     col,
  input  logic [tcw_pkg::ROW_W-1:0]     row,
  output logic [tcw_pkg::COL_W-1:0]     cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
  output logic                          scrolled,
  output logic [tcw_pkg::CHAR_W-1:0]    read_char,
  output logic [tcw_pkg::ATTR_W-1:0]    read_attr
);
  import tcw_pkg::*;

  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = CW + RW;
  localparam int DEPTH = ROWS * (2 ** CW);

  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  logic [ATTR_W-1:0] default_attr;
  logic [CW-1:0]     cur_col, cur_col_next;
  logic [RW-1:0]     cur_row, cur_row_next;
  logic              scrolled_r, scrolled_next;
  logic              rd_ok, rd_ok_next;

  // sweep walk and its delayed write stage
  logic [CW-1:0]     sw_col;
  logic [RW-1:0]     sw_row;
  logic              sw_copy;
  logic [CELL_W-1:0] sw_fill;
  logic              wr_v, wr_copy;
  logic [CW-1:0]     wr_col;
  logic [RW-1:0]     wr_row;

  logic              on_screen, put_ok, is_nl, wrap, at_last_row;
  logic              is_put, is_clear, is_read, put_we;
  logic [CW-1:0]     pc, nc;
  logic [RW-1:0]     pr, nr;
  logic [ATTR_W-1:0] put_attr;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_wa, ram_ra;
  logic [CELL_W-1:0] ram_wd, ram_rd;

  assign is_put   = (cmd_in == CMD_PUT);
  assign is_clear = (cmd_in == CMD_CLEAR);
  assign is_read  = (cmd_in == CMD_READ);

  assign on_screen = (32'(col) < COLS) && (32'(row) < ROWS);
  assign put_ok    = use_cursor || on_screen;
  assign pc        = use_cursor ? cur_col : CW'(col);
  assign pr        = use_cursor ? cur_row : RW'(row);
  assign is_nl     = (char_code == NEWLINE_CODE);
  assign put_attr  = (attr == '0) ? default_attr : attr;

  // newline jumps to the row end, then both wrap like an ordinary put
  assign wrap        = is_nl || (pc == LAST_COL);
  assign at_last_row = (pr == LAST_ROW);
  assign nc          = wrap ? '0 : CW'(pc + 1'b1);
  assign nr          = (wrap && !at_last_row) ? RW'(pr + 1'b1) : pr;

  assign stat.put_scroll = is_put && put_ok && wrap && at_last_row;
  assign stat.sweep_last = (sw_col == LAST_COL) && (sw_row == LAST_ROW);

  assign put_we = ctl.accept && is_put && put_ok && !is_nl;

  always_comb begin
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    scrolled_next = scrolled_r;
    rd_ok_next    = rd_ok;
    if (ctl.accept) begin
      scrolled_next = 1'b0;
      rd_ok_next    = 1'b0;
      if (is_put && put_ok) begin
        cur_col_next  = nc;
        cur_row_next  = nr;
        scrolled_next = stat.put_scroll;
      end else if (is_clear) begin
        cur_col_next = '0;
        cur_row_next = '0;
      end else if (is_read) begin
        rd_ok_next = on_screen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RST;
      cur_col      <= '0;
      cur_row      <= '0;
      scrolled_r   <= 1'b0;
      rd_ok        <= 1'b0;
      sw_col       <= '0;
      sw_row       <= '0;
      sw_copy      <= 1'b0;
      sw_fill      <= '0;
      wr_v         <= 1'b0;
    end else begin
      if (cfg_valid) default_attr <= cfg_data;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      scrolled_r <= scrolled_next;
      rd_ok      <= rd_ok_next;
      if (ctl.accept && stat.put_scroll) begin
        sw_copy <= 1'b1;
        sw_fill <= '0;
      end else if (ctl.accept && is_clear) begin
        sw_copy <= 1'b0;
        sw_fill <= {default_attr, SPACE_CODE};
      end
      if (ctl.step) begin
        if (sw_col == LAST_COL) begin
          sw_col <= '0;
          sw_row <= (sw_row == LAST_ROW) ? '0 : RW'(sw_row + 1'b1);
        end else begin
          sw_col <= CW'(sw_col + 1'b1);
        end
      end
      wr_v <= ctl.step;
    end
  end

  // write stage payload: cell the step read from, one row up
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      wr_col  <= sw_col;
      wr_row  <= sw_row;
      wr_copy <= sw_copy && (sw_row != LAST_ROW);
    end
  end

  // read the row below during a scroll, or the addressed cell on a read
  assign ram_re = (ctl.step && sw_copy && (sw_row != LAST_ROW))
               || (ctl.accept && is_read && on_screen);
  assign ram_ra = ctl.step ? {RW'(sw_row + 1'b1), sw_col} : {RW'(row), CW'(col)};

  assign ram_we = wr_v || put_we;
  assign ram_wa = wr_v ? {wr_row, wr_col} : {pr, pc};
  assign ram_wd = wr_v ? (wr_copy ? ram_rd : sw_fill) : {put_attr, char_code};

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      cursor_col <= COL_W'(cur_col_next);
      cursor_row <= ROW_W'(cur_row_next);
      scrolled   <= scrolled_next;
      read_char  <= rd_ok_next ? ram_rd[CHAR_W-1:0] : '0;
      read_attr  <= rd_ok_next ? ram_rd[CELL_W-1:CHAR_W] : '0;
    end
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < COLS) && (32'(cur_row) < ROWS))
    else $error("cursor left the screen");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(wr_v && put_we))
    else $error("put write collides with sweep write");
`endif

endmodule

// ===== hdl/text_console_writer.sv =====
// A put that does not scroll, or an unused command, gives its result beat in the cycle after
// acceptance; a read first passes state S_RD for the registered read port of the screen RAM.
// Puts back to back at one per cycle while m_tready is high and no put scrolls; reads do not.
// Scroll and clear walk every cell. Reset (rst, synchronous): cursor home, default attribute
// 15, then a clearing pass zeroes the screen with s_tready low; config writes are taken always.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code[7:0], attr[15:8], use_cursor[16],
                                 // col[23:17], row[28:24], zero[31:29]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_col[6:0], cursor_row[11:7], scrolled[12],
                                 // read_char[20:13], read_attr[28:21], zero[31:29]
  // default attribute register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tcw_pkg::*;

  tcw_cmd_t  ctl;
  tcw_stat_t stat;

  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic              scrolled;
  logic [CHAR_W-1:0] read_char;
  logic [ATTR_W-1:0] read_attr;

  // register accepts every beat; write it only while no item is in flight
  assign cfg_ready = 1'b1;

  // sequencing: one item in flight, the result register decouples the output side
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd_in   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // cursor, screen RAM, sweep and result payload
  tcw_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd_in     (s_tuser),
    .char_code  (s_tdata[7:0]),
    .attr       (s_tdata[15:8]),
    .use_cursor (s_tdata[16]),
    .col        (s_tdata[23:17]),
    .row        (s_tdata[28:24]),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled),
    .read_char  (read_char),
    .read_attr  (read_attr)
  );

  // pack the result beat, first field lowest
  assign m_tdata = {3'b000, read_attr, read_char, scrolled, cursor_row, cursor_col};

endmodule
